// ===== rtl/core/ersc_pkg.sv =====
// Shared types and constants for the encoder speed measurement and PWM step control.
// No dependencies; all other files of the block use these by scoped name.
package ersc_pkg;

    localparam int SPEED_W        = 40;
    localparam int DUTY_W         = 8;
    localparam int MS_W           = 8;
    localparam int QUOT_W         = 16;
    localparam int Q_FRAC_BITS    = 10;
    // product plus the largest left shift: 24 + 16 + 10
    localparam int WIDE_W         = 50;
    localparam int DIV_RADIX_LOG2 = 4;
    localparam int DIV_CYCLES     = QUOT_W / DIV_RADIX_LOG2;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [QUOT_W-1:0] MS_PER_MINUTE    = 16'd60000;
    localparam logic [DUTY_W-1:0] DUTY_MAX         = 8'd255;
    localparam logic [MS_W-1:0]   ELAPSED_MAX      = 8'd255;
    localparam logic [MS_W-1:0]   SAMPLE_PERIOD_RST = 8'd100;
    localparam logic [MS_W-1:0]   PWM_PERIOD_RST   = 8'd10;

    typedef enum logic
    {
        REG_SAMPLE_PERIOD = 1'b0,
        REG_PWM_PERIOD    = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_MEAS,
        S_CORR
    } state_t;

    typedef struct packed
    {
        logic load_item;
        logic div_step;
        logic mul;
        logic meas;
        logic corr;
    } cmd_t;

    typedef struct packed
    {
        logic div_last;
    } stat_t;

endpackage

// ===== rtl/core/ersc_regs.sv =====
// APB-style configuration registers: sample period and PWM correction period.
// Depends on ersc_pkg.
module ersc_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ersc_pkg::PADDR_W-1:0] paddr,
    input  logic [ersc_pkg::PDATA_W-1:0] pwdata,
    output logic [ersc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [ersc_pkg::MS_W-1:0]    sample_period,
    output logic [ersc_pkg::MS_W-1:0]    pwm_period
);

    logic [ersc_pkg::MS_W-1:0] sample_period_reg;
    logic [ersc_pkg::MS_W-1:0] pwm_period_reg;
    logic                      wr_en;
    ersc_pkg::reg_idx_t        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    // word addressed: byte offset bits are ignored
    assign reg_idx = ersc_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= ersc_pkg::SAMPLE_PERIOD_RST;
            pwm_period_reg    <= ersc_pkg::PWM_PERIOD_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ersc_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[ersc_pkg::MS_W-1:0];
                ersc_pkg::REG_PWM_PERIOD:    pwm_period_reg    <= pwdata[ersc_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ersc_pkg::REG_SAMPLE_PERIOD: prdata = ersc_pkg::PDATA_W'(sample_period_reg);
            ersc_pkg::REG_PWM_PERIOD:    prdata = ersc_pkg::PDATA_W'(pwm_period_reg);
            default:                     prdata = '0;
        endcase
    end

    assign sample_period = sample_period_reg;
    assign pwm_period    = pwm_period_reg;

endmodule

// ===== rtl/core/ersc_ctrl.sv =====
// Sequencer: accept, divide, multiply, measure, correct, then hand the word out.
// Depends on ersc_pkg; drives the datapath through cmd_t, reads stat_t.
module ersc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  ersc_pkg::stat_t stat,
    output ersc_pkg::cmd_t  cmd
);

    ersc_pkg::state_t state_reg;
    ersc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ersc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ersc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ersc_pkg::S_DIV;
                end
            end
            ersc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ersc_pkg::S_MUL;
                end
            end
            ersc_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ersc_pkg::S_MEAS;
            end
            ersc_pkg::S_MEAS:
            begin
                cmd.meas   = 1'b1;
                state_next = ersc_pkg::S_CORR;
            end
            ersc_pkg::S_CORR:
            begin
                // wait for room in the output register
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.corr   = 1'b1;
                    state_next = ersc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ersc_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg & out_stall) | cmd.corr;
    assign in_stall       = (state_reg != ersc_pkg::S_IDLE);
    assign out_valid      = out_valid_reg;

endmodule

// ===== rtl/core/ersc_dp.sv =====
// Datapath: edge and ms counters, radix-16 divider for 60000/period, scale multiply,
// speed saturation, duty step and the output register. Depends on ersc_pkg.
module ersc_dp
#(
    parameter int TICKS_PER_TURN_LOG2 = 10,
    parameter int TICK_COUNT_WIDTH    = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ersc_pkg::cmd_t               cmd,
    output ersc_pkg::stat_t              stat,
    input  logic [ersc_pkg::MS_W-1:0]    sample_period,
    input  logic [ersc_pkg::MS_W-1:0]    pwm_period,
    input  logic                         encoder_rise,
    input  logic                         ms_strobe,
    input  logic [ersc_pkg::SPEED_W-1:0] target_rpm_q10,
    input  logic                         halt,
    output logic [ersc_pkg::DUTY_W-1:0]  pwm_duty,
    output logic [ersc_pkg::SPEED_W-1:0] measured_rpm_q10,
    output logic                         drive_forward,
    output logic                         speed_updated
);

    localparam int PROD_W = TICK_COUNT_WIDTH + ersc_pkg::QUOT_W;
    localparam int LSH = (TICKS_PER_TURN_LOG2 < ersc_pkg::Q_FRAC_BITS) ?
                         ersc_pkg::Q_FRAC_BITS - TICKS_PER_TURN_LOG2 : 0;
    localparam int RSH = (TICKS_PER_TURN_LOG2 >= ersc_pkg::Q_FRAC_BITS) ?
                         TICKS_PER_TURN_LOG2 - ersc_pkg::Q_FRAC_BITS : 0;
    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

    logic [TICK_COUNT_WIDTH-1:0]       tick_count_reg;
    logic [ersc_pkg::SPEED_W-1:0]      speed_reg;
    logic [ersc_pkg::DUTY_W-1:0]       duty_reg;
    logic [ersc_pkg::MS_W-1:0]         sample_elapsed_reg;
    logic [ersc_pkg::MS_W-1:0]         corr_elapsed_reg;
    logic [ersc_pkg::SPEED_W-1:0]      target_reg;
    logic                              halt_reg;
    logic                              updated_reg;

    logic [ersc_pkg::MS_W-1:0]         rem_reg;
    logic [ersc_pkg::MS_W-1:0]         rem_next;
    logic [ersc_pkg::QUOT_W-1:0]       dvd_reg;
    logic [ersc_pkg::QUOT_W-1:0]       dvd_next;
    logic [ersc_pkg::QUOT_W-1:0]       quot_reg;
    logic [ersc_pkg::QUOT_W-1:0]       quot_next;
    logic [ersc_pkg::DIV_CNT_W-1:0]    div_cnt_reg;
    logic [PROD_W-1:0]                 prod_reg;

    logic [ersc_pkg::DUTY_W-1:0]       pwm_duty_reg;
    logic [ersc_pkg::SPEED_W-1:0]      measured_reg;
    logic                              drive_reg;
    logic                              speed_updated_reg;

    logic [ersc_pkg::MS_W-1:0]         divisor;
    logic [ersc_pkg::WIDE_W-1:0]       wide;
    logic [ersc_pkg::SPEED_W-1:0]      speed_sat;
    logic                              sample_due;
    logic                              corr_due;
    logic [ersc_pkg::DUTY_W-1:0]       duty_next;

    assign divisor = (sample_period == '0) ? ersc_pkg::MS_W'(1) : sample_period;

    // four restoring steps per cycle, quotient MSB first
    always_comb
    begin
        logic [ersc_pkg::MS_W:0]     r;
        logic [ersc_pkg::MS_W:0]     d;
        logic [ersc_pkg::QUOT_W-1:0] dv;
        logic [ersc_pkg::QUOT_W-1:0] q;
        d  = {1'b0, divisor};
        r  = {1'b0, rem_reg};
        dv = dvd_reg;
        q  = quot_reg;
        for (int i = 0; i < ersc_pkg::DIV_RADIX_LOG2; i++)
        begin
            r  = {r[ersc_pkg::MS_W-1:0], dv[ersc_pkg::QUOT_W-1]};
            dv = {dv[ersc_pkg::QUOT_W-2:0], 1'b0};
            if (r >= d)
            begin
                r = r - d;
                q = {q[ersc_pkg::QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q = {q[ersc_pkg::QUOT_W-2:0], 1'b0};
            end
        end
        rem_next  = r[ersc_pkg::MS_W-1:0];
        dvd_next  = dv;
        quot_next = q;
    end

    assign stat.div_last = (div_cnt_reg == ersc_pkg::DIV_CNT_W'(ersc_pkg::DIV_CYCLES - 1));

    // Q10 alignment of ticks * factor, clamp to 40 bits
    assign wide      = (ersc_pkg::WIDE_W'(prod_reg) << LSH) >> RSH;
    assign speed_sat = (|wide[ersc_pkg::WIDE_W-1:ersc_pkg::SPEED_W]) ? '1 :
                       wide[ersc_pkg::SPEED_W-1:0];

    assign sample_due = (sample_elapsed_reg >= sample_period);
    assign corr_due   = (corr_elapsed_reg >= pwm_period);

    always_comb
    begin
        duty_next = duty_reg;
        if (corr_due && !halt_reg)
        begin
            if (target_reg > speed_reg && duty_reg != ersc_pkg::DUTY_MAX)
            begin
                duty_next = duty_reg + ersc_pkg::DUTY_W'(1);
            end
            else if (target_reg < speed_reg && duty_reg != '0)
            begin
                duty_next = duty_reg - ersc_pkg::DUTY_W'(1);
            end
        end
        if (halt_reg)
        begin
            duty_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg     <= '0;
            speed_reg          <= '0;
            duty_reg           <= '0;
            sample_elapsed_reg <= '0;
            corr_elapsed_reg   <= '0;
            updated_reg        <= 1'b0;
            div_cnt_reg        <= '0;
            measured_reg       <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                if (encoder_rise && tick_count_reg != TICK_MAX)
                begin
                    tick_count_reg <= tick_count_reg + TICK_COUNT_WIDTH'(1);
                end
                if (ms_strobe)
                begin
                    if (sample_elapsed_reg != ersc_pkg::ELAPSED_MAX)
                    begin
                        sample_elapsed_reg <= sample_elapsed_reg + ersc_pkg::MS_W'(1);
                    end
                    if (corr_elapsed_reg != ersc_pkg::ELAPSED_MAX)
                    begin
                        corr_elapsed_reg <= corr_elapsed_reg + ersc_pkg::MS_W'(1);
                    end
                end
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + ersc_pkg::DIV_CNT_W'(1);
            end
            if (cmd.meas)
            begin
                updated_reg <= sample_due;
                if (sample_due)
                begin
                    speed_reg          <= speed_sat;
                    tick_count_reg     <= '0;
                    sample_elapsed_reg <= '0;
                end
            end
            if (cmd.corr)
            begin
                duty_reg     <= duty_next;
                measured_reg <= speed_reg;
                if (corr_due)
                begin
                    corr_elapsed_reg <= '0;
                end
            end
        end
    end

    // item latches, divider and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            target_reg <= target_rpm_q10;
            halt_reg   <= halt;
            rem_reg    <= '0;
            dvd_reg    <= ersc_pkg::MS_PER_MINUTE;
            quot_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            quot_reg <= quot_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(tick_count_reg) * PROD_W'(quot_reg);
        end
        if (cmd.corr)
        begin
            pwm_duty_reg      <= duty_next;
            drive_reg         <= !halt_reg;
            speed_updated_reg <= updated_reg;
        end
    end

    assign pwm_duty         = pwm_duty_reg;
    assign measured_rpm_q10 = measured_reg;
    assign drive_forward    = drive_reg;
    assign speed_updated    = speed_updated_reg;

endmodule

// ===== rtl/core/encoder_rpm_step_speed_control.sv =====
// Top level of the encoder speed measurement with one-step PWM duty correction.
// Depends on ersc_pkg, ersc_regs, ersc_ctrl and ersc_dp.
//
//   channel  handshake                  payload
//   in       in_valid / in_stall        encoder_rise, ms_strobe, target_rpm_q10, halt
//   out      out_valid / out_stall      pwm_duty, measured_rpm_q10, drive_forward, speed_updated
//   cfg      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each word is accepted, then runs the radix-16 divider for 60000/period, a multiply,
// a measure and a correction step that loads the output register; the input stalls until then.
// The result shows in the cycle after that last step; a new word can be taken while it waits.
// A stalled output holds the sequencer in its correction step until the register frees.
// Reset (async, rst_n low) clears counters, speed, duty and the output valid.
module encoder_rpm_step_speed_control
#(
    parameter int TICKS_PER_TURN_LOG2 = 10,
    parameter int TICK_COUNT_WIDTH    = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         encoder_rise,
    input  logic                         ms_strobe,
    input  logic [ersc_pkg::SPEED_W-1:0] target_rpm_q10,
    input  logic                         halt,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ersc_pkg::DUTY_W-1:0]  pwm_duty,
    output logic [ersc_pkg::SPEED_W-1:0] measured_rpm_q10,
    output logic                         drive_forward,
    output logic                         speed_updated,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ersc_pkg::PADDR_W-1:0] paddr,
    input  logic [ersc_pkg::PDATA_W-1:0] pwdata,
    output logic [ersc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic [ersc_pkg::MS_W-1:0] sample_period;
    logic [ersc_pkg::MS_W-1:0] pwm_period;
    ersc_pkg::cmd_t            cmd;
    ersc_pkg::stat_t           stat;

    ersc_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sample_period (sample_period),
        .pwm_period    (pwm_period)
    );

    ersc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ersc_dp
    #(
        .TICKS_PER_TURN_LOG2 (TICKS_PER_TURN_LOG2),
        .TICK_COUNT_WIDTH    (TICK_COUNT_WIDTH)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .sample_period    (sample_period),
        .pwm_period       (pwm_period),
        .encoder_rise     (encoder_rise),
        .ms_strobe        (ms_strobe),
        .target_rpm_q10   (target_rpm_q10),
        .halt             (halt),
        .pwm_duty         (pwm_duty),
        .measured_rpm_q10 (measured_rpm_q10),
        .drive_forward    (drive_forward),
        .speed_updated    (speed_updated)
    );

    // one word in flight: an accepted word blocks the input for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a word is in flight");

    // a halted word always carries zero duty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drive_forward) |-> (pwm_duty == '0))
        else $error("halted word with nonzero duty");

    // a new result only follows a word that was being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an accepted word");

    // speed changes only on a measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && !speed_updated) |-> $stable(measured_rpm_q10))
        else $error("speed changed without a measurement");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for encoder_rpm_step_speed_control: speed measurement and duty stepping.
// Needs ersc_pkg and the block's RTL; predicts each output word and compares it on the fly.
module testbench;

    localparam int SPEED_W       = ersc_pkg::SPEED_W;
    localparam int DUTY_W        = ersc_pkg::DUTY_W;
    localparam int MS_W          = ersc_pkg::MS_W;
    localparam int TICK_W        = 24;
    localparam int TICKS_LOG2    = 10;
    localparam int FRAC_BITS     = ersc_pkg::Q_FRAC_BITS;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int SHOWN_ERRORS  = 10;

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};

    typedef enum int
    {
        AIM_MAX,
        AIM_ZERO,
        AIM_SPEED,
        AIM_NEAR,
        AIM_WIDE
    } aim_t;

    typedef struct packed
    {
        logic               rise;
        logic               strobe;
        logic [SPEED_W-1:0] target;
        logic               halt;
        logic               match;   // target is replaced by the speed it will be compared with
    } in_word_t;

    typedef struct packed
    {
        logic [DUTY_W-1:0]  duty;
        logic [SPEED_W-1:0] speed;
        logic               drive;
        logic               updated;
    } out_word_t;

    typedef struct packed
    {
        logic [TICK_W-1:0]  ticks;
        logic [SPEED_W-1:0] speed;
        logic [DUTY_W-1:0]  duty;
        logic [MS_W-1:0]    sample_ms;
        logic [MS_W-1:0]    corr_ms;
    } ctrl_state_t;

    typedef struct packed
    {
        ctrl_state_t st;
        out_word_t   res;
    } ctrl_step_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   encoder_rise = 1'b0;
    logic                   ms_strobe = 1'b0;
    logic [SPEED_W-1:0]     target_rpm_q10 = '0;
    logic                   halt = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [DUTY_W-1:0]      pwm_duty;
    logic [SPEED_W-1:0]     measured_rpm_q10;
    logic                   drive_forward;
    logic                   speed_updated;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ersc_pkg::PADDR_W-1:0] paddr = '0;
    logic [ersc_pkg::PDATA_W-1:0] pwdata = '0;
    logic [ersc_pkg::PDATA_W-1:0] prdata;
    logic                   pready;

    encoder_rpm_step_speed_control dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .encoder_rise     (encoder_rise),
        .ms_strobe        (ms_strobe),
        .target_rpm_q10   (target_rpm_q10),
        .halt             (halt),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pwm_duty         (pwm_duty),
        .measured_rpm_q10 (measured_rpm_q10),
        .drive_forward    (drive_forward),
        .speed_updated    (speed_updated),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    in_word_t        pending_q[$];
    out_word_t       expected_q[$];
    ctrl_state_t     model_st = '0;
    logic [MS_W-1:0] cfg_sample = ersc_pkg::SAMPLE_PERIOD_RST;
    logic [MS_W-1:0] cfg_pwm = ersc_pkg::PWM_PERIOD_RST;
    int              mismatch_cnt = 0;
    int              idle_cycles = 0;
    logic            in_fire = 1'b0;

    // One word through the speed/duty controller.
    function automatic ctrl_step_t ctrl_step(input ctrl_state_t s, input in_word_t w,
                                             input logic [MS_W-1:0] sp,
                                             input logic [MS_W-1:0] pp);
        ctrl_step_t o;
        logic [63:0] prod;
        logic [15:0] scale;
        logic [MS_W-1:0] div;
        o.st = s;
        o.res.updated = 1'b0;
        if (w.rise && o.st.ticks != TICK_MAX)
            o.st.ticks = o.st.ticks + TICK_W'(1);
        if (w.strobe)
        begin
            if (o.st.sample_ms != ersc_pkg::ELAPSED_MAX)
                o.st.sample_ms = o.st.sample_ms + MS_W'(1);
            if (o.st.corr_ms != ersc_pkg::ELAPSED_MAX)
                o.st.corr_ms = o.st.corr_ms + MS_W'(1);
        end
        if (o.st.sample_ms >= sp)
        begin
            div = (sp == '0) ? MS_W'(1) : sp;
            scale = ersc_pkg::MS_PER_MINUTE / 16'(div);
            prod = 64'(o.st.ticks) * 64'(scale);
            if (TICKS_LOG2 >= FRAC_BITS)
                prod = prod >> (TICKS_LOG2 - FRAC_BITS);
            else
                prod = prod << (FRAC_BITS - TICKS_LOG2);
            o.st.speed = (prod > 64'(SPEED_MAX)) ? SPEED_MAX : prod[SPEED_W-1:0];
            o.st.ticks = '0;
            o.st.sample_ms = '0;
            o.res.updated = 1'b1;
        end
        if (o.st.corr_ms >= pp)
        begin
            if (!w.halt)
            begin
                if (w.target > o.st.speed && o.st.duty != ersc_pkg::DUTY_MAX)
                    o.st.duty = o.st.duty + DUTY_W'(1);
                else if (w.target < o.st.speed && o.st.duty != '0)
                    o.st.duty = o.st.duty - DUTY_W'(1);
            end
            o.st.corr_ms = '0;
        end
        if (w.halt)
            o.st.duty = '0;
        o.res.duty = o.st.duty;
        o.res.speed = o.st.speed;
        o.res.drive = !w.halt;
        return o;
    endfunction

    // Sender: bursts of words separated by random gaps.
    int         burst_left = 1;
    int         gap_left = 0;
    in_word_t   drv_word;
    ctrl_step_t drv_peek;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left != 0 || pending_q.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                drv_word = pending_q.pop_front();
                if (drv_word.match)
                begin
                    // speed does not depend on the target, so peek ahead with any
                    drv_peek = ctrl_step(model_st, drv_word, cfg_sample, cfg_pwm);
                    drv_word.target = drv_peek.st.speed;
                end
                in_valid <= 1'b1;
                encoder_rise <= drv_word.rise;
                ms_strobe <= drv_word.strobe;
                target_rpm_q10 <= drv_word.target;
                halt <= drv_word.halt;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver stall pattern: modes held for random spans.
    int stall_mode = 0;
    int stall_span = 0;
    int stall_run = 0;

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 200);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (stall_run != 0)
                begin
                    out_stall <= 1'b1;
                    stall_run <= stall_run - 1;
                end
                else
                begin
                    out_stall <= 1'b0;
                    if ($urandom_range(0, 9) == 0)
                        stall_run <= $urandom_range(5, 20);
                end
            end
        endcase
    end

    // Monitor: predict on input accept, check on output accept, watchdog.
    in_word_t   mon_word;
    ctrl_step_t mon_next;
    out_word_t  mon_exp;

    always @(posedge clk)
    begin
        in_fire <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatch_cnt < SHOWN_ERRORS)
                        $display("unexpected word: duty %0d rpm %0h drive %0b upd %0b",
                                 pwm_duty, measured_rpm_q10, drive_forward, speed_updated);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                else
                begin
                    mon_exp = expected_q.pop_front();
                    if (pwm_duty !== mon_exp.duty || measured_rpm_q10 !== mon_exp.speed ||
                        drive_forward !== mon_exp.drive || speed_updated !== mon_exp.updated)
                    begin
                        if (mismatch_cnt < SHOWN_ERRORS)
                            $display("mismatch: duty %0d/%0d rpm %0h/%0h drive %0b/%0b upd %0b/%0b",
                                     mon_exp.duty, pwm_duty, mon_exp.speed, measured_rpm_q10,
                                     mon_exp.drive, drive_forward,
                                     mon_exp.updated, speed_updated);
                        mismatch_cnt = mismatch_cnt + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                mon_word = '0;
                mon_word.rise = encoder_rise;
                mon_word.strobe = ms_strobe;
                mon_word.target = target_rpm_q10;
                mon_word.halt = halt;
                mon_next = ctrl_step(model_st, mon_word, cfg_sample, cfg_pwm);
                model_st <= mon_next.st;
                expected_q.push_back(mon_next.res);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic rise, input logic strobe,
                              input logic [SPEED_W-1:0] target, input logic hold,
                              input logic match);
        in_word_t w;
        w.rise = rise;
        w.strobe = strobe;
        w.target = target;
        w.halt = hold;
        w.match = match;
        pending_q.push_back(w);
    endtask

    // Segments with a common aim for the target and their own edge/strobe density.
    task automatic queue_random(input int count);
        aim_t        aim;
        int          seg_len;
        int          edge_pct;
        int          strobe_pct;
        int          halt_pct;
        logic [63:0] r64;
        logic [SPEED_W-1:0] tgt;
        while (count > 0)
        begin
            aim = aim_t'($urandom_range(0, 4));
            seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 300)
                                                  : $urandom_range(10, 80);
            edge_pct = $urandom_range(0, 100);
            strobe_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 100);
            halt_pct = ($urandom_range(0, 3) == 0) ? 10 : 0;
            while (seg_len > 0 && count > 0)
            begin
                r64 = {$urandom, $urandom};
                case (aim)
                    AIM_MAX:  tgt = SPEED_MAX;
                    AIM_ZERO: tgt = '0;
                    AIM_NEAR: tgt = SPEED_W'($urandom_range(0, 300000));
                    default:  tgt = r64[SPEED_W-1:0];
                endcase
                queue_word($urandom_range(0, 99) < edge_pct,
                           $urandom_range(0, 99) < strobe_pct,
                           tgt,
                           $urandom_range(0, 99) < halt_pct,
                           aim == AIM_SPEED);
                seg_len = seg_len - 1;
                count = count - 1;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ersc_pkg::reg_idx_t idx, input logic [MS_W-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == ersc_pkg::REG_SAMPLE_PERIOD)
            cfg_sample = val;
        else
            cfg_pwm = val;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    logic [MS_W-1:0] phase_sample;
    logic [MS_W-1:0] phase_pwm;

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset periods
        queue_word(1'b0, 1'b0, '0, 1'b0, 1'b0);
        queue_word(1'b1, 1'b1, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b1, 1'b1, SPEED_MAX, 1'b1, 1'b0);
        wait_drained();

        // every word with a ms strobe measures and corrects
        write_reg(ersc_pkg::REG_SAMPLE_PERIOD, 8'd1);
        write_reg(ersc_pkg::REG_PWM_PERIOD, 8'd1);
        queue_word(1'b1, 1'b1, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b1, 1'b1, '0, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, '0, 1'b0, 1'b0);        // target equals zero speed
        queue_word(1'b1, 1'b1, '0, 1'b0, 1'b1);        // target equals new speed
        queue_word(1'b1, 1'b1, SPEED_MAX, 1'b1, 1'b0); // halt while due
        queue_word(1'b0, 1'b0, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b1, 1'b0, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b1, 1'b0, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b1, 1'b0, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b1, 1'b1, SPEED_MAX, 1'b0, 1'b0);
        queue_word(1'b1, 1'b1, 40'd120000, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, 40'd1, 1'b0, 1'b0);
        queue_word(1'b1, 1'b0, SPEED_MAX, 1'b1, 1'b0);
        wait_drained();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: begin phase_sample = 8'd1;   phase_pwm = 8'd1;   end
                1: begin phase_sample = 8'd255; phase_pwm = 8'd255; end
                2: begin phase_sample = 8'd1;   phase_pwm = 8'd255; end
                3: begin phase_sample = 8'd255; phase_pwm = 8'd1;   end
                6: begin phase_sample = 8'd100; phase_pwm = 8'd10;  end
                default:
                begin
                    phase_sample = MS_W'($urandom_range(1, 255));
                    phase_pwm = MS_W'($urandom_range(1, 20));
                end
            endcase
            write_reg(ersc_pkg::REG_SAMPLE_PERIOD, phase_sample);
            write_reg(ersc_pkg::REG_PWM_PERIOD, phase_pwm);
            // first phase is long enough to ramp the duty into both rails
            queue_random(phase == 0 ? 450 : 215);
            wait_drained();
        end

        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== encoder_rpm_step_speed_control.f =====
rtl/core/ersc_pkg.sv
rtl/core/ersc_regs.sv
rtl/core/ersc_ctrl.sv
rtl/core/ersc_dp.sv
rtl/core/encoder_rpm_step_speed_control.sv
tb/sv/testbench.sv
